@@ src/locd_pkg.sv @@
// Package for the LED output command decoder: channel payload structs,
// command record passed from the front end to the sequencer, and constants.
// No dependencies.
`default_nettype none

package locd_pkg;

    localparam int BANK_COUNT_DEFAULT = 4;
    localparam int MAX_BANKS          = 4;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [6:0] REPORT_LEN  = 7'd8;
    localparam logic [7:0] CMD_SWITCH  = 8'd64;
    localparam logic [7:0] PROF_LO_MAX = 8'd49;
    localparam logic [7:0] PROF_HI_MIN = 8'd129;
    localparam logic [7:0] PROF_HI_MAX = 8'd132;
    localparam logic [2:0] PERIOD_MASK = 3'h7;
    localparam logic [4:0] POS_STEP    = 5'd8;
    localparam logic [4:0] PROF_LAST   = 5'd7;

    typedef enum logic {
        KIND_SWITCH  = 1'b0,
        KIND_PROFILE = 1'b1
    } t_cmd_kind;

    typedef struct packed {
        logic [6:0] report_length;
        logic [7:0] command_byte;
        logic [7:0] data_byte1;
        logic [7:0] data_byte2;
        logic [7:0] data_byte3;
        logic [7:0] data_byte4;
        logic [7:0] data_byte5;
        logic [7:0] data_byte6;
        logic [7:0] data_byte7;
    } t_locd_in;

    typedef struct packed {
        logic       command_kind;
        logic [5:0] port_number;
        logic       port_on;
        logic [2:0] flash_period;
        logic [7:0] profile_value;
        logic       last_of_run;
    } t_locd_out;

    // Decoded command as queued between front end and sequencer.
    typedef struct packed {
        t_cmd_kind   kind;
        logic [4:0]  base;    // port offset of first result, minus one
        logic [2:0]  period;  // already clamped to 1..7
        logic [63:0] bytes;   // report byte i at [8*i +: 8]
    } t_locd_cmd;

    // Queue flags seen by the producer and consumer.
    typedef struct packed {
        logic full;
        logic not_empty;
    } t_locd_qstat;

endpackage

`default_nettype wire

@@ src/locd_front.sv @@
// Front end of the LED output command decoder: accepts reports, classifies
// them and tracks the profile position. Depends on locd_pkg.
`default_nettype none

module locd_front
    import locd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire t_locd_in    i_data,
    input  wire t_locd_qstat i_qstat,
    output logic             o_push,
    output t_locd_cmd        o_cmd
);

    logic [4:0] r_profile_position;
    logic [4:0] n_profile_position;
    logic       accept;
    logic       len_ok;
    logic       is_switch;
    logic       is_profile;
    logic [2:0] period_raw;

    assign o_stall = i_qstat.full;
    assign accept  = i_valid && !i_qstat.full;

    assign len_ok     = (i_data.report_length == REPORT_LEN);
    assign is_switch  = len_ok && (i_data.command_byte == CMD_SWITCH);
    assign is_profile = len_ok && ((i_data.command_byte <= PROF_LO_MAX) ||
                        ((i_data.command_byte >= PROF_HI_MIN) &&
                         (i_data.command_byte <= PROF_HI_MAX)));

    assign period_raw = i_data.data_byte5[2:0] & PERIOD_MASK;

    always_comb begin
        o_push       = accept && (is_switch || is_profile);
        o_cmd.kind   = is_switch ? KIND_SWITCH : KIND_PROFILE;
        o_cmd.base   = is_switch ? 5'd0 : r_profile_position;
        o_cmd.period = (period_raw == 3'd0) ? 3'd1 : period_raw;
        o_cmd.bytes  = {i_data.data_byte7, i_data.data_byte6, i_data.data_byte5,
                        i_data.data_byte4, i_data.data_byte3, i_data.data_byte2,
                        i_data.data_byte1, i_data.command_byte};

        n_profile_position = r_profile_position;
        if (accept && is_switch) begin
            n_profile_position = 5'd0;
        end else if (accept && is_profile) begin
            n_profile_position = r_profile_position + POS_STEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_profile_position <= 5'd0;
        end else begin
            r_profile_position <= n_profile_position;
        end
    end

    a_switch_clears_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_switch) |=> (r_profile_position == 5'd0))
        else $error("profile position not cleared by switch command");

    a_pos_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_profile_position[2:0] == 3'd0)
        else $error("profile position lost 8-port alignment");

endmodule

`default_nettype wire

@@ src/locd_queue.sv @@
// Short command queue between front end and sequencer.
// Depends on locd_pkg.
`default_nettype none

module locd_queue
    import locd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_locd_cmd i_cmd,
    input  wire logic      i_pop,
    output t_locd_cmd      o_cmd,
    output t_locd_qstat    o_qstat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    t_locd_cmd        r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_qstat.full      = (r_count == FULL_CNT);
    assign o_qstat.not_empty = (r_count != '0);
    assign o_cmd             = r_mem[r_rd_ptr];
    assign do_push           = i_push && !o_qstat.full;
    assign do_pop            = i_pop && o_qstat.not_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count beyond depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !o_qstat.not_empty) |-> !i_push || (r_count == '0))
        else $error("pop on empty queue");

endmodule

`default_nettype wire

@@ src/locd_back.sv @@
// Sequencer of the LED output command decoder: expands one queued command
// into per-port results through an output register. Depends on locd_pkg.
`default_nettype none

module locd_back
    import locd_pkg::*;
#(
    parameter int BANK_COUNT = BANK_COUNT_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_locd_cmd   i_cmd,
    input  wire t_locd_qstat i_qstat,
    output logic             o_pop,
    output logic             o_valid,
    input  wire logic        i_stall,
    output t_locd_out        o_data
);

    localparam logic [4:0] SWITCH_LAST = 5'(BANK_COUNT * 8 - 1);

    logic       r_busy;
    logic       n_busy;
    t_locd_cmd  r_cmd;
    logic [4:0] r_idx;
    logic [4:0] n_idx;
    logic       r_out_valid;
    logic       n_out_valid;
    t_locd_out  r_out;
    t_locd_out  n_out;
    logic [4:0] last_idx;
    logic       load;
    logic       is_last;

    assign o_valid  = r_out_valid;
    assign o_data   = r_out;
    assign o_pop    = !r_busy && i_qstat.not_empty;
    assign last_idx = (r_cmd.kind == KIND_SWITCH) ? SWITCH_LAST : PROF_LAST;
    assign is_last  = (r_idx == last_idx);
    assign load     = r_busy && (!r_out_valid || !i_stall);

    always_comb begin
        n_busy      = r_busy;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && i_stall;
        n_out       = r_out;

        if (o_pop) begin
            n_busy = 1'b1;
            n_idx  = 5'd0;
        end else if (load) begin
            n_out_valid        = 1'b1;
            n_out.command_kind = r_cmd.kind;
            n_out.port_number  = {1'b0, r_cmd.base} + {1'b0, r_idx} + 6'd1;
            n_out.last_of_run  = is_last;
            if (r_cmd.kind == KIND_SWITCH) begin
                n_out.port_on       = r_cmd.bytes[{1'b0, r_idx} + 6'd8];
                n_out.flash_period  = r_cmd.period;
                n_out.profile_value = 8'd0;
            end else begin
                n_out.port_on       = 1'b0;
                n_out.flash_period  = 3'd0;
                n_out.profile_value = r_cmd.bytes[{r_idx[2:0], 3'b000} +: 8];
            end
            if (is_last) begin
                n_busy = 1'b0;
            end else begin
                n_idx = r_idx + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        r_idx <= n_idx;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= last_idx))
        else $error("result index past end of command");

    a_port_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.port_number >= 6'd1) && (o_data.port_number <= 6'd32))
        else $error("port number out of range");

    a_profile_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.command_kind) |->
            (!o_data.port_on && (o_data.flash_period == 3'd0)))
        else $error("profile result carries switch fields");

endmodule

`default_nettype wire

@@ src/led_output_command_decoder.sv @@
// Top level of the LED output command decoder: front end, command queue
// and result sequencer. Depends on locd_pkg, locd_front, locd_queue, locd_back.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------------
//  report  | in        | i_valid / o_stall       | i_data (t_locd_in)
//  result  | out       | o_valid / i_stall       | o_data (t_locd_out)
//
// A report is classified in the cycle it transfers; a valid command is queued
// (2 entries) and the report port stays open until the queue fills.
// The sequencer then gives one result per cycle while i_stall is low:
// BANK_COUNT*8 results for a switch command, 8 for a profile command, and
// fetches the next queued command once the last result is loaded.
// Wrong-length and unknown reports transfer like any other and give nothing.
// i_stall holds the output register; the sequencer waits, the queue keeps
// accepting. Synchronous active-low reset clears position, queue and valid.
`default_nettype none

module led_output_command_decoder
    import locd_pkg::*;
#(
    parameter int BANK_COUNT = BANK_COUNT_DEFAULT
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_locd_in i_data,
    output logic          o_valid,
    input  wire logic     i_stall,
    output t_locd_out     o_data
);

    t_locd_qstat qstat;
    t_locd_cmd   push_cmd;
    t_locd_cmd   head_cmd;
    logic        push;
    logic        pop;

    // Classify and track the profile position.
    locd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .i_qstat (qstat),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    // Decouples report intake from result expansion.
    locd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_qstat (qstat)
    );

    // Expand each command into per-port results.
    locd_back #(
        .BANK_COUNT (BANK_COUNT)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (head_cmd),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule

`default_nettype wire

@@ sim/locd_result_checker.sv @@
// Port-update checker for the LED output command decoder: watches both channels,
// predicts the per-port updates of each accepted report and compares them in order.
// Depends on locd_pkg.
`timescale 1ns / 1ps

module locd_result_checker
    import locd_pkg::*;
#(
    parameter int BANK_COUNT = BANK_COUNT_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_rpt_valid,
    input  logic      i_rpt_stall,
    input  t_locd_in  i_rpt_data,
    input  logic      i_upd_valid,
    input  logic      i_upd_stall,
    input  t_locd_out i_upd_data,
    output int        o_fail_count,
    output int        o_pending
);

    t_locd_out  pending_port_updates[$];
    logic [4:0] prof_pos;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        prof_pos     = '0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s got %0d want %0d", $time, what, got, want);
        o_fail_count++;
    endtask

    // Appends the updates one report should cause; moves the profile position.
    function automatic void predict_port_updates(input t_locd_in rpt);
        logic [7:0] rpt_bytes [8];
        logic [2:0] period;
        t_locd_out  upd;
        int         n;
        rpt_bytes = '{rpt.command_byte, rpt.data_byte1, rpt.data_byte2, rpt.data_byte3,
                      rpt.data_byte4, rpt.data_byte5, rpt.data_byte6, rpt.data_byte7};
        if (rpt.report_length != REPORT_LEN) begin
            return;
        end
        if (rpt.command_byte == CMD_SWITCH) begin
            period = rpt.data_byte5[2:0] & PERIOD_MASK;
            if (period == 3'd0) begin
                period = 3'd1;
            end
            for (n = 0; n < BANK_COUNT * 8; n++) begin
                upd.command_kind  = KIND_SWITCH;
                upd.port_number   = 6'(n + 1);
                upd.port_on       = rpt_bytes[1 + n / 8][n % 8];
                upd.flash_period  = period;
                upd.profile_value = 8'd0;
                upd.last_of_run   = (n == BANK_COUNT * 8 - 1);
                pending_port_updates.push_back(upd);
            end
            prof_pos = '0;
        end else if (rpt.command_byte <= PROF_LO_MAX ||
                     (rpt.command_byte >= PROF_HI_MIN && rpt.command_byte <= PROF_HI_MAX)) begin
            for (n = 0; n < 8; n++) begin
                upd.command_kind  = KIND_PROFILE;
                upd.port_number   = 6'(int'(prof_pos) + n + 1);
                upd.port_on       = 1'b0;
                upd.flash_period  = 3'd0;
                upd.profile_value = rpt_bytes[n];
                upd.last_of_run   = (n == 7);
                pending_port_updates.push_back(upd);
            end
            prof_pos = prof_pos + POS_STEP;
        end
    endfunction

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch(name, got, want);
        end
    endtask

    always @(posedge i_clk) begin
        t_locd_out want;
        if (i_rst_n) begin
            if (i_rpt_valid && !i_rpt_stall) begin
                predict_port_updates(i_rpt_data);
            end
            if (i_upd_valid && !i_upd_stall) begin
                if (pending_port_updates.size() == 0) begin
                    report_mismatch("update with none expected, port", i_upd_data.port_number, 0);
                end else begin
                    want = pending_port_updates.pop_front();
                    check_field("command_kind", i_upd_data.command_kind, want.command_kind);
                    check_field("port_number", i_upd_data.port_number, want.port_number);
                    check_field("port_on", i_upd_data.port_on, want.port_on);
                    check_field("flash_period", i_upd_data.flash_period, want.flash_period);
                    check_field("profile_value", i_upd_data.profile_value,
                                want.profile_value);
                    check_field("last_of_run", i_upd_data.last_of_run, want.last_of_run);
                end
            end
        end
        o_pending = pending_port_updates.size();
    end

endmodule

@@ sim/led_output_command_decoder_tb.sv @@
// Testbench top for the LED output command decoder: clock, reset, report source,
// update sink with random stalls, watchdog and verdict.
// Depends on locd_pkg, led_output_command_decoder and locd_result_checker.
`timescale 1ns / 1ps

module led_output_command_decoder_tb;
    import locd_pkg::*;

    localparam int BANK_COUNT     = BANK_COUNT_DEFAULT;
    localparam int ITEM_TARGET    = 88;    // reports of every kind in the random part
    localparam int HOLD_CYCLES    = 300;   // long sink hold-off to back up the queue
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer on either side
    localparam int DRAIN_CYCLES   = 40;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_locd_in  i_data  = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_locd_out o_data;

    int fail_count;
    int pending;
    int idle_cycles = 0;

    // Written by the report source only (nonblocking), read by the sink.
    logic quiet    = 1'b0;  // no idling on either side
    logic hold_req = 1'b0;  // ask the sink for its one long hold-off

    led_output_command_decoder #(
        .BANK_COUNT(BANK_COUNT)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data)
    );

    locd_result_checker #(
        .BANK_COUNT(BANK_COUNT)
    ) checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rpt_valid (i_valid),
        .i_rpt_stall (o_stall),
        .i_rpt_data  (i_data),
        .i_upd_valid (o_valid),
        .i_upd_stall (i_stall),
        .i_upd_data  (o_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Report with random payload bytes; the caller picks length and command.
    function automatic t_locd_in random_report(input logic [6:0] len, input logic [7:0] cmd);
        t_locd_in rpt;
        rpt.report_length = len;
        rpt.command_byte  = cmd;
        rpt.data_byte1    = 8'($urandom);
        rpt.data_byte2    = 8'($urandom);
        rpt.data_byte3    = 8'($urandom);
        rpt.data_byte4    = 8'($urandom);
        rpt.data_byte5    = 8'($urandom);
        rpt.data_byte6    = 8'($urandom);
        rpt.data_byte7    = 8'($urandom);
        return rpt;
    endfunction

    // Called at a falling edge. Idles a random number of cycles, then offers the
    // report until the transfer happens; returns at the next falling edge.
    // Valid is only dropped for a real gap, so back-to-back offers keep it high.
    task automatic send_report(input t_locd_in rpt);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_data  <= rpt;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Report source: directed corner cases, then the random mix.
    initial begin : report_source
        t_locd_in   rpt;
        int         counted;
        int         sel;
        logic [6:0] len;
        logic [7:0] cmd;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // wrong lengths, including both ends of the 7-bit field: dropped silently
        send_report(random_report(7'd0, CMD_SWITCH));
        send_report(random_report(7'd7, CMD_SWITCH));
        send_report(random_report(7'd9, CMD_SWITCH));
        send_report(random_report(7'd127, CMD_SWITCH));
        send_report(random_report(7'd64, 8'd0));

        // switch: all off with a zero period field (clamps to 1)
        rpt = random_report(REPORT_LEN, CMD_SWITCH);
        rpt.data_byte1 = 8'h00;
        rpt.data_byte2 = 8'h00;
        rpt.data_byte3 = 8'h00;
        rpt.data_byte4 = 8'h00;
        rpt.data_byte5 = 8'hF8;
        send_report(rpt);
        // switch: all on, max period, upper period bits set
        rpt = random_report(REPORT_LEN, CMD_SWITCH);
        rpt.data_byte1 = 8'hFF;
        rpt.data_byte2 = 8'hFF;
        rpt.data_byte3 = 8'hFF;
        rpt.data_byte4 = 8'hFF;
        rpt.data_byte5 = 8'hFF;
        send_report(rpt);
        // switch: bit ordering within each bank
        rpt = random_report(REPORT_LEN, CMD_SWITCH);
        rpt.data_byte1 = 8'hA5;
        rpt.data_byte2 = 8'h5A;
        rpt.data_byte3 = 8'h01;
        rpt.data_byte4 = 8'h80;
        rpt.data_byte5 = 8'h03;
        send_report(rpt);

        // profile: range ends, four in a row wrap the position, then two more
        send_report(random_report(REPORT_LEN, 8'd0));
        send_report(random_report(REPORT_LEN, PROF_LO_MAX));
        send_report(random_report(REPORT_LEN, PROF_HI_MIN));
        send_report(random_report(REPORT_LEN, PROF_HI_MAX));
        send_report(random_report(REPORT_LEN, 8'd17));
        send_report(random_report(REPORT_LEN, 8'd130));
        // switch in mid-run clears the position
        send_report(random_report(REPORT_LEN, CMD_SWITCH));
        send_report(random_report(REPORT_LEN, 8'd5));

        // undefined commands right next to the valid ranges, and the top code
        send_report(random_report(REPORT_LEN, 8'd50));
        send_report(random_report(REPORT_LEN, 8'd63));
        send_report(random_report(REPORT_LEN, 8'd65));
        send_report(random_report(REPORT_LEN, 8'd128));
        send_report(random_report(REPORT_LEN, 8'd133));
        send_report(random_report(REPORT_LEN, 8'd255));

        // Random mix, mostly well-formed commands. Around report 30 the sink goes
        // quiet for a long stretch while reports keep coming back to back, so the
        // queue fills and the input stalls. A later window runs with no idling.
        counted = 0;
        while (counted < ITEM_TARGET) begin
            quiet    <= (counted >= 30 && counted < 42) || (counted >= 70 && counted < 85);
            hold_req <= (counted >= 30);
            sel = $urandom_range(0, 99);
            if (sel < 8) begin
                // broken length: anything but 8
                len = 7'($urandom_range(0, 127));
                if (len == REPORT_LEN) begin
                    len = 7'($urandom_range(9, 127));
                end
                send_report(random_report(len, 8'($urandom)));
            end else if (sel < 16) begin
                // undefined command
                cmd = 8'($urandom_range(50, 255));
                while (cmd == CMD_SWITCH || (cmd >= PROF_HI_MIN && cmd <= PROF_HI_MAX)) begin
                    cmd = 8'($urandom_range(50, 255));
                end
                send_report(random_report(REPORT_LEN, cmd));
            end else if (sel < 58) begin
                if ($urandom_range(0, 3) == 0) begin
                    cmd = 8'($urandom_range(PROF_HI_MIN, PROF_HI_MAX));
                end else begin
                    cmd = 8'($urandom_range(0, PROF_LO_MAX));
                end
                send_report(random_report(REPORT_LEN, cmd));
            end else begin
                send_report(random_report(REPORT_LEN, CMD_SWITCH));
            end
            counted++;
        end
        i_valid <= 1'b0;
        quiet   <= 1'b0;

        // wait out every expected update, then a few cycles for strays
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Update sink: after each transfer draws a random stall (none in a
    // quiet window). Once asked, holds stall high for its one long hold-off.
    initial begin : update_sink
        int wait_left;
        bit took;
        bit hold_done;
        wait_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            took = (o_valid === 1'b1) && !i_stall;
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
            end else begin
                if (took) begin
                    wait_left = quiet ? 0 : $urandom_range(0, 10);
                end
                if (wait_left > 0) begin
                    i_stall <= 1'b1;
                    wait_left--;
                end else begin
                    i_stall <= 1'b0;
                end
            end
        end
    end

    // Watchdog: ends the run if neither channel transfers for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid === 1'b1 && !i_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule
